// ----- rtl/tbvs_pkg.sv -----
// ----------------------------------------------------------------------------
// tbvs_pkg
// shared types and constants of the two-bone vertex skinning block
// ----------------------------------------------------------------------------
`default_nettype none

package tbvs_pkg;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_VERTEX = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  localparam int unsigned ELEMS      = 12;
  localparam int unsigned LAST_ELEM  = ELEMS - 1;
  localparam int unsigned DVS_W      = 17;  // weight total
  localparam int unsigned QUO_W      = 33;  // quotient magnitude bits
  localparam int unsigned DVD_W      = DVS_W + QUO_W;
  localparam int unsigned DIV_SPS    = 4;   // quotient bits per divider stage
  localparam int unsigned DIV_STAGES = (QUO_W + DIV_SPS - 1) / DIV_SPS;

  typedef logic [ELEMS-1:0][31:0] row_t;

  // sideband that travels alongside the divider
  typedef struct packed {
    logic             blend;
    logic [2:0]       neg;
    logic [2:0][31:0] pos;
  } side_t;

endpackage

`default_nettype wire

// ----- rtl/tbvs_div.sv -----
// ----------------------------------------------------------------------------
// tbvs_div
// pipelined unsigned divider, three lanes sharing one divisor
// ----------------------------------------------------------------------------
`default_nettype none

module tbvs_div (
  input  wire                                          clk_i,
  input  wire                                          rst_ni,
  input  wire                                          en_i,
  input  wire                                          vld_i,
  input  wire  [2:0][tbvs_pkg::DVD_W-1:0]              dvd_i,
  input  wire  [tbvs_pkg::DVS_W-1:0]                   dvs_i,
  input  tbvs_pkg::side_t                              side_i,
  output logic                                         vld_o,
  output logic [2:0][tbvs_pkg::QUO_W-1:0]              quo_o,
  output tbvs_pkg::side_t                              side_o
);
  import tbvs_pkg::*;

  logic [DIV_STAGES-1:0]                    vld_q;
  logic [2:0][DVS_W-1:0]                    rem_q  [DIV_STAGES];
  logic [2:0][QUO_W-1:0]                    low_q  [DIV_STAGES];
  logic [DVS_W-1:0]                         dvs_q  [DIV_STAGES];
  side_t                                    side_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [2:0][DVS_W-1:0] rem_in, rem_d;
    logic [2:0][QUO_W-1:0] low_in, low_d;
    logic [DVS_W-1:0]      dvs_in;
    side_t                 side_in;
    logic                  vld_in;

    if (s == 0) begin : g_first
      always_comb begin
        for (int ln = 0; ln < 3; ln++) begin
          rem_in[ln] = dvd_i[ln][DVD_W-1:QUO_W];
          low_in[ln] = dvd_i[ln][QUO_W-1:0];
        end
        dvs_in  = dvs_i;
        side_in = side_i;
        vld_in  = vld_i;
      end
    end else begin : g_next
      always_comb begin
        rem_in  = rem_q[s-1];
        low_in  = low_q[s-1];
        dvs_in  = dvs_q[s-1];
        side_in = side_q[s-1];
        vld_in  = vld_q[s-1];
      end
    end

    // restoring steps, one quotient bit each
    always_comb begin
      logic [DVS_W:0] t;
      rem_d = rem_in;
      low_d = low_in;
      for (int ln = 0; ln < 3; ln++) begin
        for (int k = 0; k < DIV_SPS; k++) begin
          if (s * DIV_SPS + k < QUO_W) begin
            t = {rem_d[ln], low_d[ln][QUO_W-1]};
            low_d[ln] = {low_d[ln][QUO_W-2:0], 1'b0};
            if (t >= {1'b0, dvs_in}) begin
              rem_d[ln]    = DVS_W'(t - {1'b0, dvs_in});
              low_d[ln][0] = 1'b1;
            end else begin
              rem_d[ln] = t[DVS_W-1:0];
            end
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        low_q[s]  <= low_d;
        dvs_q[s]  <= dvs_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[DIV_STAGES-1];
  assign quo_o  = low_q[DIV_STAGES-1];
  assign side_o = side_q[DIV_STAGES-1];

endmodule

`default_nettype wire

// ----- rtl/two_bone_vertex_skinning.sv -----
// ----------------------------------------------------------------------------
// two_bone_vertex_skinning
// linear blend skinning with two bone influences per vertex
// ----------------------------------------------------------------------------
// The block takes one beat per cycle unless a result beat is held at the
// output, and returns one result beat per vertex beat. Load and clear beats
// return nothing. Bone matrices live in one memory with a 384-bit row per
// bone, written one element at a time and read at the two bone rows of a
// vertex in the cycle it is taken; since writes and reads both happen at
// acceptance, a vertex sees every load taken before it. Present marks are
// flip-flops cleared at once by a clear beat. The rate is set by the
// pipeline: a matrix read stage, a row multiply stage, a round and saturate
// stage, a weight multiply stage, a sum stage, a nine-stage divider retiring
// four quotient bits per stage and one in the last, and an output register.
// The whole pipeline moves when the output register is empty or being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module two_bone_vertex_skinning #(
  parameter int unsigned BONE_COUNT = 64
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // table_bone, table_element, table_value, pos_x, pos_y, pos_z,
  // first_bone, first_weight, second_bone, second_weight, zero pad
  input  wire  [183:0] s_axis_tdata_i,
  // mode
  input  wire  [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  wire          m_axis_tready_i,
  // out_x, out_y, out_z
  output logic [95:0]  m_axis_tdata_o,
  // blended
  output logic         m_axis_tuser_o
);
  import tbvs_pkg::*;

  localparam int unsigned BW = (BONE_COUNT > 1) ? $clog2(BONE_COUNT) : 1;

  // input field split
  logic [5:0]        tbl_bone;
  logic [3:0]        tbl_elem;
  logic [31:0]       tbl_val;
  logic [2:0][31:0]  pos_in;
  logic [5:0]        bone0, bone1;
  logic [15:0]       wgt0, wgt1;
  logic              s_acc, en;

  assign tbl_bone  = s_axis_tdata_i[5:0];
  assign tbl_elem  = s_axis_tdata_i[9:6];
  assign tbl_val   = s_axis_tdata_i[41:10];
  assign pos_in[0] = s_axis_tdata_i[73:42];
  assign pos_in[1] = s_axis_tdata_i[105:74];
  assign pos_in[2] = s_axis_tdata_i[137:106];
  assign bone0     = s_axis_tdata_i[143:138];
  assign wgt0      = s_axis_tdata_i[159:144];
  assign bone1     = s_axis_tdata_i[165:160];
  assign wgt1      = s_axis_tdata_i[181:166];

  // global pipeline advance: output register empty or draining
  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign s_acc           = s_axis_tvalid_i && en;

  // --------------------------------------------------------------------------
  // matrix memory and present marks
  // --------------------------------------------------------------------------
  row_t                  mat_mem [BONE_COUNT];
  logic [BONE_COUNT-1:0] present_q, present_d;
  logic [BW-1:0]         wr_idx, rd_idx0, rd_idx1;
  logic                  wr_ok, ok0, ok1;

  assign wr_idx  = BW'(tbl_bone);
  assign rd_idx0 = BW'(bone0);
  assign rd_idx1 = BW'(bone1);
  assign wr_ok   = (32'(tbl_bone) < BONE_COUNT) && (32'(tbl_elem) < ELEMS);
  // an out-of-range or absent bone takes no weight
  assign ok0     = (32'(bone0) < BONE_COUNT) && present_q[rd_idx0];
  assign ok1     = (32'(bone1) < BONE_COUNT) && present_q[rd_idx1];

  always_ff @(posedge clk_i) begin
    if (s_acc && s_axis_tuser_i == MODE_LOAD && wr_ok) begin
      mat_mem[wr_idx][tbl_elem] <= tbl_val;
    end
  end

  always_comb begin
    present_d = present_q;
    if (s_acc && s_axis_tuser_i == MODE_CLEAR) begin
      present_d = '0;
    end else if (s_acc && s_axis_tuser_i == MODE_LOAD && wr_ok &&
                 32'(tbl_elem) == LAST_ELEM) begin
      present_d[wr_idx] = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: registered row read, effective weights
  // --------------------------------------------------------------------------
  row_t             rd0_q, rd1_q;
  logic             v1_q;
  logic [1:0][15:0] w1_q;
  logic [2:0][31:0] pos1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rd0_q   <= mat_mem[rd_idx0];
      rd1_q   <= mat_mem[rd_idx1];
      w1_q[0] <= ok0 ? wgt0 : 16'd0;
      w1_q[1] <= ok1 ? wgt1 : 16'd0;
      pos1_q  <= pos_in;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: matrix by position products
  // --------------------------------------------------------------------------
  logic                  v2_q;
  logic [1:0][15:0]      w2_q;
  logic [2:0][31:0]      pos2_q;
  logic [63:0]           prod_q  [2][3][3];
  logic [31:0]           trans_q [2][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int b = 0; b < 2; b++) begin
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            prod_q[b][r][c] <= 64'($signed(b == 0 ? rd0_q[r*4+c] : rd1_q[r*4+c])
                                 * $signed(pos1_q[c]));
          end
          trans_q[b][r] <= (b == 0) ? rd0_q[r*4+3] : rd1_q[r*4+3];
        end
      end
      w2_q   <= w1_q;
      pos2_q <= pos1_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: round each product, add translation, saturate
  // --------------------------------------------------------------------------
  logic             v3_q;
  logic [1:0][15:0] w3_q;
  logic [2:0][31:0] pos3_q;
  logic [31:0]      t_q [2][3];
  logic [31:0]      t_d [2][3];

  always_comb begin
    logic signed [63:0] rp;
    logic signed [49:0] acc;
    for (int b = 0; b < 2; b++) begin
      for (int r = 0; r < 3; r++) begin
        acc = 50'($signed(trans_q[b][r]));
        for (int c = 0; c < 3; c++) begin
          rp  = $signed(prod_q[b][r][c]) + 64'sd32768;
          acc = acc + 50'($signed(rp[63:16]));
        end
        if (acc > 50'sd2147483647) begin
          t_d[b][r] = 32'h7fff_ffff;
        end else if (acc < -50'sd2147483648) begin
          t_d[b][r] = 32'h8000_0000;
        end else begin
          t_d[b][r] = acc[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_q    <= t_d;
      w3_q   <= w2_q;
      pos3_q <= pos2_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: weighting
  // --------------------------------------------------------------------------
  logic             v4_q;
  logic [DVS_W-1:0] tot4_q;
  logic [2:0][31:0] pos4_q;
  logic [48:0]      tw_q [2][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int b = 0; b < 2; b++) begin
        for (int r = 0; r < 3; r++) begin
          tw_q[b][r] <= 49'($signed(t_q[b][r]) * $signed({1'b0, w3_q[b]}));
        end
      end
      tot4_q <= DVS_W'(w3_q[0]) + DVS_W'(w3_q[1]);
      pos4_q <= pos3_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: numerator sum, sign and rounded magnitude
  // --------------------------------------------------------------------------
  logic                  v5_q;
  logic [2:0][DVD_W-1:0] dvd5_q;
  logic [DVS_W-1:0]      tot5_q;
  side_t                 side5_q;

  always_ff @(posedge clk_i) begin
    logic signed [DVD_W-1:0] num;
    logic [DVD_W-1:0]        mag;
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        num = DVD_W'($signed(tw_q[0][r])) + DVD_W'($signed(tw_q[1][r]));
        mag = num[DVD_W-1] ? DVD_W'(-num) : DVD_W'(num);
        dvd5_q[r]      <= mag + DVD_W'(tot4_q >> 1);
        side5_q.neg[r] <= num[DVD_W-1];
      end
      tot5_q        <= tot4_q;
      side5_q.blend <= (tot4_q != '0);
      side5_q.pos   <= pos4_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      v5_q      <= 1'b0;
    end else begin
      present_q <= present_d;
      if (en) begin
        v1_q <= s_acc && s_axis_tuser_i == MODE_VERTEX;
        v2_q <= v1_q;
        v3_q <= v2_q;
        v4_q <= v3_q;
        v5_q <= v4_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // divider and output register
  // --------------------------------------------------------------------------
  logic                  dv_vld;
  logic [2:0][QUO_W-1:0] dv_quo;
  side_t                 dv_side;

  tbvs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v5_q),
    .dvd_i  (dvd5_q),
    .dvs_i  (tot5_q),
    .side_i (side5_q),
    .vld_o  (dv_vld),
    .quo_o  (dv_quo),
    .side_o (dv_side)
  );

  logic [95:0] res_d;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (!dv_side.blend) begin
        res_d[r*32 +: 32] = dv_side.pos[r];
      end else if (dv_side.neg[r]) begin
        res_d[r*32 +: 32] = (dv_quo[r] > QUO_W'(33'h0_8000_0000)) ? 32'h8000_0000
                                                                  : 32'(-dv_quo[r]);
      end else begin
        res_d[r*32 +: 32] = (dv_quo[r] > QUO_W'(33'h0_7fff_ffff)) ? 32'h7fff_ffff
                                                                  : dv_quo[r][31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid_o <= 1'b0;
    end else if (en) begin
      m_axis_tvalid_o <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_axis_tdata_o <= res_d;
      m_axis_tuser_o <= dv_side.blend;
    end
  end

`ifndef NO_ASSERTIONS
  // a clear beat drops every present mark
  a_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && s_axis_tuser_i == MODE_CLEAR |=> present_q == '0)
    else $error("present marks not cleared");

  // a valid last-element load marks its bone present
  a_mark : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && s_axis_tuser_i == MODE_LOAD && wr_ok && 32'(tbl_elem) == LAST_ELEM
    |=> present_q[$past(wr_idx)])
    else $error("bone not marked present");

  // the input stalls only behind a held result beat
  a_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without held result");
`endif

endmodule

`default_nettype wire
